// ===== rtl/ecmp_pkg.sv =====
package ecmp_pkg;

  localparam int unsigned ROUTE_ENTRIES_DEF = 256;
  localparam int unsigned MAX_HOPS_DEF      = 16;
  localparam int unsigned PORT_COUNT_DEF    = 64;

  localparam int unsigned PORT_W = 6;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_ROUTE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_LIST_FULL  = 2'd3;

  localparam logic [7:0] PROTO_TCP  = 8'h06;
  localparam logic [7:0] PROTO_UDP  = 8'h11;
  localparam logic [7:0] PROTO_EXP0 = 8'hFC;
  localparam logic [7:0] PROTO_EXP1 = 8'hFD;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_E  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
  localparam logic [31:0] MM_LEN = 32'd12;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_HASH_SEED = 1'd0;

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== rtl/ecmp_hash.sv =====
module ecmp_hash import ecmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] seed_i,
  input  logic [31:0] word0_i,
  input  logic [31:0] word1_i,
  input  logic [31:0] word2_i,
  output logic        done_o,
  output logic [31:0] hash_o
);

  typedef enum logic [2:0] {HS_IDLE, HS_K1, HS_K2, HS_H, HS_F1, HS_F2, HS_F3} hstate_e;

  hstate_e     state_q;
  logic [1:0]  blk_q;
  logic        done_q;
  logic [31:0] k_q, h_q, w0_q, w1_q, w2_q;
  logic [31:0] word, hx, fin, mul_a, mul_b, prod;

  always_comb begin
    case (blk_q)
      2'd0:    word = w0_q;
      2'd1:    word = w1_q;
      default: word = w2_q;
    endcase
    hx  = rotl32(h_q ^ k_q, 13);
    fin = h_q ^ MM_LEN;
    fin = fin ^ (fin >> 16);
    case (state_q)
      HS_K1: begin
        mul_a = word;
        mul_b = MM_C1;
      end
      HS_K2: begin
        mul_a = rotl32(k_q, 15);
        mul_b = MM_C2;
      end
      HS_F1: begin
        mul_a = fin;
        mul_b = MM_F1;
      end
      HS_F2: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = MM_F2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      blk_q   <= 2'd0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      state_q <= HS_K1;
      blk_q   <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        HS_K1: state_q <= HS_K2;
        HS_K2: state_q <= HS_H;
        HS_H: begin
          blk_q   <= blk_q + 2'd1;
          state_q <= (blk_q == 2'd2) ? HS_F1 : HS_K1;
        end
        HS_F1: state_q <= HS_F2;
        HS_F2: state_q <= HS_F3;
        HS_F3: begin
          done_q  <= 1'b1;
          state_q <= HS_IDLE;
        end
        default: state_q <= HS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q  <= seed_i;
      w0_q <= word0_i;
      w1_q <= word1_i;
      w2_q <= word2_i;
    end else begin
      case (state_q)
        HS_K1, HS_K2: k_q <= prod;
        HS_H:         h_q <= (hx << 2) + hx + MM_E;
        HS_F1, HS_F2: h_q <= prod;
        HS_F3:        h_q <= h_q ^ (h_q >> 16);
        default:      h_q <= h_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

// ===== rtl/ecmp_mod.sv =====
module ecmp_mod import ecmp_pkg::*; #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      value_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  logic             busy_q, done_q;
  logic [4:0]       step_q;
  logic [31:0]      val_q;
  logic [CNT_W-1:0] div_q, rem_q, rem_d;
  logic [CNT_W:0]   t;

  // one quotient bit per cycle, most significant first
  always_comb begin
    t = {rem_q, val_q[31]};
    if (t >= {1'b0, div_q}) begin
      t = t - {1'b0, div_q};
    end
    rem_d = t[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

// ===== rtl/ecmp_next_hop_select.sv =====
// ECMP next-hop select. An add appends port_in to the hop list of dest_addr
// (creating the route), a clear empties the table, and a lookup hashes
// {src_addr, dest_addr, ports} with 32-bit MurmurHash3 under hash_seed and
// returns hop list entry (hash mod list length); the ports word is zero
// unless the protocol is TCP, UDP or experimental 0xFC/0xFD. Routes live in a
// route memory searched one entry per clock, and the hash shares one 32x32
// multiplier over 12 steps while the modulo retires one bit per cycle.
// A new item is taken while the previous result word still waits at the
// output. No clearing pass is needed after reset.
module ecmp_next_hop_select import ecmp_pkg::*; #(
  parameter int unsigned ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int unsigned MAX_HOPS      = MAX_HOPS_DEF,
  parameter int unsigned PORT_COUNT    = PORT_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [31:0]       dest_addr_i,
  input  logic [31:0]       src_addr_i,
  input  logic [7:0]        protocol_i,
  input  logic [15:0]       src_port_i,
  input  logic [15:0]       dst_port_i,
  input  logic [PORT_W-1:0] port_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [PORT_W-1:0] out_port_o
);

  localparam int unsigned RW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned NW  = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned CW  = $clog2(MAX_HOPS + 1);
  localparam int unsigned HW  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int unsigned HD  = ROUTE_ENTRIES * MAX_HOPS;
  localparam int unsigned HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned PCW = $clog2(PORT_COUNT + 1);
  localparam int unsigned XW  = (PCW > PORT_W) ? PCW : PORT_W;
  localparam int unsigned EW  = 32 + CW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_HASH, S_MOD, S_HOP, S_RESULT
  } state_e;

  state_e            state_q;
  logic [31:0]       seed_q;
  logic [NW-1:0]     fill_q, scan_q;
  logic              pend_q;
  logic [RW-1:0]     rd_idx_q, ridx_q;
  logic [CW-1:0]     cnt_q;
  logic [1:0]        act_q, stat_q;
  logic [31:0]       dest_q;
  logic [PORT_W-1:0] pin_q, port_q;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [PORT_W-1:0] out_port_q;

  logic [EW-1:0]     route_mem [ROUTE_ENTRIES];
  logic [PORT_W-1:0] hop_mem [HD];
  logic [EW-1:0]     rte_rd_q;
  logic [PORT_W-1:0] hop_rd_q;

  logic              in_acc, out_free, pin_ok, found, issue;
  logic [31:0]       port_word;
  logic              rte_we, hop_we;
  logic [RW-1:0]     rte_waddr;
  logic [EW-1:0]     rte_wdata;
  logic [HAW-1:0]    hop_waddr, hop_raddr;
  logic [CW-1:0]     rd_cnt;
  logic              hash_done, mod_done;
  logic [31:0]       hash_val;
  logic [HW-1:0]     rem;

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_HASH_SEED) ? seed_q : 32'd0;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pin_ok     = XW'(port_in_i) < XW'(PORT_COUNT);
  assign rd_cnt     = rte_rd_q[CW-1:0];
  assign found      = pend_q && (rte_rd_q[EW-1:CW] == dest_q);
  assign issue      = (state_q == S_SCAN) && !found && (scan_q < fill_q);

  always_comb begin
    port_word = 32'd0;
    if (protocol_i == PROTO_TCP || protocol_i == PROTO_UDP ||
        protocol_i == PROTO_EXP0 || protocol_i == PROTO_EXP1) begin
      port_word = {dst_port_i, src_port_i};
    end
  end

  ecmp_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && action_i == ACT_LOOKUP),
    .seed_i  (seed_q),
    .word0_i (src_addr_i),
    .word1_i (dest_addr_i),
    .word2_i (port_word),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  ecmp_mod #(
    .CNT_W (CW),
    .IDX_W (HW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_HASH && hash_done),
    .value_i   (hash_val),
    .divisor_i (cnt_q),
    .done_o    (mod_done),
    .rem_o     (rem)
  );

  // write back route entry and hop slot at the end of a scan
  always_comb begin
    rte_we    = 1'b0;
    hop_we    = 1'b0;
    rte_waddr = fill_q[RW-1:0];
    rte_wdata = {dest_q, CW'(1)};
    hop_waddr = HAW'(HAW'(fill_q[RW-1:0]) * HAW'(MAX_HOPS));
    if (state_q == S_SCAN && act_q == ACT_ADD) begin
      if (found) begin
        rte_waddr = rd_idx_q;
        rte_wdata = {dest_q, rd_cnt + CW'(1)};
        hop_waddr = HAW'(HAW'(rd_idx_q) * HAW'(MAX_HOPS) + HAW'(rd_cnt));
        rte_we    = rd_cnt < CW'(MAX_HOPS);
        hop_we    = rte_we;
      end else if (!issue) begin
        rte_we = fill_q < NW'(ROUTE_ENTRIES);
        hop_we = rte_we;
      end
    end
    hop_raddr = HAW'(HAW'(ridx_q) * HAW'(MAX_HOPS) + HAW'(rem));
  end

  always_ff @(posedge clk_i) begin
    if (rte_we) begin
      route_mem[rte_waddr] <= rte_wdata;
    end
    rte_rd_q <= route_mem[scan_q[RW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hop_we) begin
      hop_mem[hop_waddr] <= pin_q;
    end
    hop_rd_q <= hop_mem[hop_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 32'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_HASH_SEED) begin
      seed_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_port_q   <= '0;
    end else begin
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            scan_q <= '0;
            pend_q <= 1'b0;
            case (action_i)
              ACT_LOOKUP: state_q <= S_SCAN;
              ACT_ADD:    state_q <= pin_ok ? S_SCAN : S_RESULT;
              ACT_CLEAR: begin
                fill_q  <= '0;
                state_q <= S_RESULT;
              end
              default:    state_q <= S_RESULT;
            endcase
          end
        end
        S_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            scan_q <= scan_q + NW'(1);
          end
          if (found) begin
            if (act_q == ACT_LOOKUP && rd_cnt != '0) begin
              state_q <= S_HASH;
            end else begin
              state_q <= S_RESULT;
            end
          end else if (!issue) begin
            if (rte_we) begin
              fill_q <= fill_q + NW'(1);
            end
            state_q <= S_RESULT;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_q <= S_HOP;
          end
        end
        S_HOP: state_q <= S_RESULT;
        S_RESULT: begin
          if (out_free) begin
            out_status_q <= stat_q;
            out_port_q   <= port_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      dest_q <= dest_addr_i;
      pin_q  <= port_in_i;
      stat_q <= ST_OK;
      port_q <= '0;
    end else begin
      case (state_q)
        S_SCAN: begin
          if (found) begin
            ridx_q <= rd_idx_q;
            cnt_q  <= rd_cnt;
            if (act_q == ACT_LOOKUP && rd_cnt == '0) begin
              stat_q <= ST_NO_ROUTE;
            end else if (act_q == ACT_ADD && !rte_we) begin
              stat_q <= ST_LIST_FULL;
            end
          end else if (!issue) begin
            if (act_q == ACT_LOOKUP) begin
              stat_q <= ST_NO_ROUTE;
            end else if (!rte_we) begin
              stat_q <= ST_TABLE_FULL;
            end
          end
          if (issue) begin
            rd_idx_q <= scan_q[RW-1:0];
          end
        end
        S_HOP:   port_q <= hop_rd_q;
        default: port_q <= port_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_port_o  = out_port_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NW'(ROUTE_ENTRIES))
    else $error("route fill count beyond table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> scan_q <= fill_q)
    else $error("route scan ran past installed routes");

  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> out_port_o == '0)
    else $error("nonzero port on failed result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted word did not start processing");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hop_we |-> rte_we && state_q == S_SCAN)
    else $error("hop write without route update");

endmodule

// ===== verif/ecmp_route_checker.sv =====
module ecmp_route_checker import ecmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [31:0]       dest_addr_i,
  input  logic [31:0]       src_addr_i,
  input  logic [7:0]        protocol_i,
  input  logic [15:0]       src_port_i,
  input  logic [15:0]       dst_port_i,
  input  logic [PORT_W-1:0] port_in_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [1:0]        status_o,
  input  logic [PORT_W-1:0] out_port_o,
  output int unsigned       mismatches,
  output int unsigned       pending,
  output int unsigned       checked,
  output int unsigned       hits
);

  typedef struct packed {
    logic [1:0]        status;
    logic [PORT_W-1:0] port;
  } route_result_t;

  route_result_t     result_q[$];
  logic [31:0]       seed;
  bit                route_on [ROUTE_ENTRIES_DEF];
  logic [31:0]       route_key[ROUTE_ENTRIES_DEF];
  int unsigned       hops     [ROUTE_ENTRIES_DEF];
  logic [PORT_W-1:0] hop_tab  [ROUTE_ENTRIES_DEF][MAX_HOPS_DEF];

  function automatic logic [31:0] mix_word(logic [31:0] h, logic [31:0] k);
    k = k * MM_C1;
    k = {k[16:0], k[31:17]};
    k = k * MM_C2;
    h = h ^ k;
    h = {h[18:0], h[31:19]};
    return h * 32'd5 + MM_E;
  endfunction

  function automatic logic [31:0] flow_hash(logic [31:0] s, logic [31:0] d,
                                            logic [31:0] pw, logic [31:0] sd);
    logic [31:0] h;
    h = mix_word(sd, s);
    h = mix_word(h, d);
    h = mix_word(h, pw);
    h = h ^ MM_LEN;
    h = h ^ (h >> 16);
    h = h * MM_F1;
    h = h ^ (h >> 13);
    h = h * MM_F2;
    return h ^ (h >> 16);
  endfunction

  function automatic int find_route(logic [31:0] d);
    for (int i = 0; i < ROUTE_ENTRIES_DEF; i++)
      if (route_on[i] && route_key[i] == d) return i;
    return -1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    route_result_t got, want;
    logic [31:0]   pw;
    int            r;
    if (!rst_ni) begin
      seed = '0;
      foreach (route_on[i]) route_on[i] = 1'b0;
      result_q.delete();
      mismatches = 0;
      checked = 0;
      hits = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_HASH_SEED)
        seed = pwdata;
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, out_port_o};
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: status %0d port %0d", got.status, got.port);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on word %0d: expected status %0d port %0d, got %0d %0d",
                       checked, want.status, want.port, got.status, got.port);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = '{ST_OK, '0};
        case (action_i)
          ACT_LOOKUP: begin
            r = find_route(dest_addr_i);
            if (r < 0 || hops[r] == 0) begin
              want.status = ST_NO_ROUTE;
            end else begin
              pw = '0;
              if (protocol_i inside {PROTO_TCP, PROTO_UDP, PROTO_EXP0, PROTO_EXP1})
                pw = {dst_port_i, src_port_i};
              want.port = hop_tab[r][flow_hash(src_addr_i, dest_addr_i, pw, seed) % hops[r]];
              hits++;
            end
          end
          ACT_ADD: begin
            if (port_in_i < PORT_COUNT_DEF) begin
              r = find_route(dest_addr_i);
              if (r < 0) begin
                for (r = 0; r < ROUTE_ENTRIES_DEF; r++)
                  if (!route_on[r]) break;
                if (r >= ROUTE_ENTRIES_DEF) begin
                  want.status = ST_TABLE_FULL;
                end else begin
                  route_on[r]   = 1'b1;
                  route_key[r]  = dest_addr_i;
                  hops[r]       = 1;
                  hop_tab[r][0] = port_in_i;
                end
              end else if (hops[r] >= MAX_HOPS_DEF) begin
                want.status = ST_LIST_FULL;
              end else begin
                hop_tab[r][hops[r]] = port_in_i;
                hops[r]++;
              end
            end
          end
          ACT_CLEAR: foreach (route_on[i]) route_on[i] = 1'b0;
          default: ;
        endcase
        result_q = {result_q, want};
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== verif/ecmp_next_hop_select_test.sv =====
module ecmp_next_hop_select_test;
  import ecmp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i = ACT_LOOKUP;
  logic [31:0]       dest_addr_i = '0, src_addr_i = '0;
  logic [7:0]        protocol_i = '0;
  logic [15:0]       src_port_i = '0, dst_port_i = '0;
  logic [PORT_W-1:0] port_in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [PORT_W-1:0] out_port_o;

  int unsigned mismatches, pending, checked, hits;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  logic [31:0] dest_pool[6];

  ecmp_next_hop_select DUT (.*);
  ecmp_route_checker checker_i (.*);

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output stall: runs of free cycles and stalls, mostly short
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_on || $urandom_range(1) == 0) begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(6);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
    end
  end

  task automatic write_seed(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_HASH_SEED, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic send(logic [1:0] act, logic [31:0] dest, logic [31:0] src,
                      logic [7:0] proto, logic [15:0] sp, logic [15:0] dp,
                      logic [PORT_W-1:0] pin);
    int unsigned r, gap;
    r = $urandom_range(99);
    gap = (!gaps_on || r < 60) ? 0 : (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act; dest_addr_i <= dest; src_addr_i <= src;
    protocol_i <= proto; src_port_i <= sp; dst_port_i <= dp; port_in_i <= pin;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_proto();
    logic [7:0] known[4] = '{PROTO_TCP, PROTO_UDP, PROTO_EXP0, PROTO_EXP1};
    return ($urandom_range(9) < 6) ? known[$urandom_range(3)] : 8'($urandom);
  endfunction

  task automatic random_words(int unsigned n);
    int unsigned r;
    logic [31:0] d;
    foreach (dest_pool[i]) dest_pool[i] = $urandom;
    repeat (n) begin
      r = $urandom_range(99);
      d = ($urandom_range(9) == 0) ? $urandom : dest_pool[$urandom_range(5)];
      if (r < 48)
        send(ACT_LOOKUP, d, $urandom, pick_proto(), 16'($urandom), 16'($urandom),
             PORT_W'($urandom));
      else if (r < 95)
        send(ACT_ADD, d, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
             PORT_W'($urandom));
      else if (r < 97)
        send(ACT_CLEAR, $urandom, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
             PORT_W'($urandom));
      else
        send(ACT_RSVD, d, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
             PORT_W'($urandom));
      if ($urandom_range(49) == 0) gaps_on = !gaps_on;
    end
    gaps_on = 1'b1;
    drop_valid();
  endtask

  initial begin : stimulus
    logic [31:0] base;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, odd actions, extremes, every hashed protocol
    write_seed(32'hffffffff);
    send(ACT_LOOKUP, 32'h0, 32'h0, PROTO_TCP, 16'h0, 16'h0, '0);
    send(ACT_CLEAR, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff, 16'hffff, '1);
    send(ACT_RSVD, 32'h0, 32'h0, 8'h0, 16'h0, 16'h0, '0);
    send(ACT_ADD, 32'hffffffff, 32'h0, 8'h0, 16'h0, 16'h0, '0);
    send(ACT_ADD, 32'hffffffff, 32'h0, 8'h0, 16'h0, 16'h0, '1);
    send(ACT_ADD, 32'hffffffff, 32'h0, 8'h0, 16'h0, 16'h0, 6'd21);
    send(ACT_LOOKUP, 32'hffffffff, 32'hffffffff, PROTO_TCP, 16'hffff, 16'hffff, '0);
    send(ACT_LOOKUP, 32'hffffffff, 32'h0, PROTO_UDP, 16'h0, 16'hffff, '0);
    send(ACT_LOOKUP, 32'hffffffff, 32'h12345678, PROTO_EXP0, 16'hffff, 16'h0, '0);
    send(ACT_LOOKUP, 32'hffffffff, 32'h9abcdef0, PROTO_EXP1, 16'h1234, 16'h8765, '0);
    send(ACT_LOOKUP, 32'hffffffff, 32'h9abcdef0, 8'h00, 16'h1234, 16'h8765, '0);
    send(ACT_LOOKUP, 32'hffffffff, 32'h9abcdef0, 8'hff, 16'hffff, 16'hffff, '0);
    send(ACT_LOOKUP, 32'h0, 32'h0, PROTO_UDP, 16'h0, 16'h0, '0);
    send(ACT_CLEAR, 32'h0, 32'h0, 8'h0, 16'h0, 16'h0, '0);
    send(ACT_LOOKUP, 32'hffffffff, 32'h0, PROTO_TCP, 16'h0, 16'h0, '0);
    // fill one hop list and go one past it
    for (int i = 0; i < MAX_HOPS_DEF + 1; i++)
      send(ACT_ADD, 32'h0, 32'h0, 8'h0, 16'h0, 16'h0, PORT_W'(i * 3));
    send(ACT_LOOKUP, 32'h0, 32'hdeadbeef, PROTO_TCP, 16'h50, 16'h1f90, '0);
    drop_valid();
    wait_idle();

    write_seed(32'h0);
    random_words(200);
    wait_idle();

    write_seed($urandom);
    stall_on = 1'b0;
    random_words(60);
    stall_on = 1'b1;
    random_words(120);
    wait_idle();

    // fill the whole table, then push new routes into it
    write_seed(32'h80000000);
    base = $urandom;
    send(ACT_CLEAR, 32'h0, 32'h0, 8'h0, 16'h0, 16'h0, '0);
    for (int i = 0; i < ROUTE_ENTRIES_DEF; i++)
      send(ACT_ADD, base + i, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
           PORT_W'($urandom));
    for (int i = 0; i < 12; i++) begin
      send(ACT_ADD, base + ROUTE_ENTRIES_DEF + i, $urandom, 8'($urandom), 16'($urandom),
           16'($urandom), PORT_W'($urandom));
      send(ACT_LOOKUP, base + $urandom_range(ROUTE_ENTRIES_DEF - 1), $urandom, pick_proto(),
           16'($urandom), 16'($urandom), PORT_W'($urandom));
      send(ACT_ADD, base + $urandom_range(ROUTE_ENTRIES_DEF - 1), $urandom, 8'($urandom),
           16'($urandom), 16'($urandom), PORT_W'($urandom));
    end
    drop_valid();
    wait_idle();

    write_seed($urandom);
    random_words(195);
    wait_idle();
    repeat (100) @(negedge clk_i);

    $display("sent %0d words (%0d routed lookups) under five seed settings,", words_sent, hits);
    $display("including a full table, full hop lists and every hashed protocol");
    if (mismatches == 0 && pending == 0 && checked == words_sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== ecmp_next_hop_select.f =====
rtl/ecmp_pkg.sv
rtl/ecmp_hash.sv
rtl/ecmp_mod.sv
rtl/ecmp_next_hop_select.sv
verif/ecmp_route_checker.sv
verif/ecmp_next_hop_select_test.sv
